[rtl/isucc_pkg.sv]
// isucc_pkg: shared types, sizes and bit-search helpers for the integer set
// successor block. Used by every module under rtl/; depends on nothing.
package isucc_pkg;

  // Key space and bitmap geometry
  localparam int KEY_W      = 16;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int LEAF_W     = KEY_W - WORD_SHIFT;
  localparam int MID_W      = LEAF_W - WORD_SHIFT;
  localparam int LEAF_WORDS = 1 << LEAF_W;
  localparam int MID_WORDS  = 1 << MID_W;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_SHIFT-1:0] lane_t;
  typedef logic [LEAF_W-1:0]     leaf_idx_t;
  typedef logic [MID_W-1:0]      mid_idx_t;
  typedef logic [MID_WORDS-1:0]  top_vec_t;
  typedef logic [KEY_W-1:0]      key_t;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SUCC   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Input transaction
  typedef struct packed {
    logic [1:0] op;
    key_t       key;
  } isucc_in_t;

  // Result transaction
  typedef struct packed {
    logic found;
    key_t next_key;
  } isucc_out_t;

  // Summary lookup for the key of an accepted transaction
  typedef struct packed {
    logic     leaf_ok;   // leaf word of the key has been written
    logic     mid_hit;   // a later nonzero leaf word in the same mid word
    lane_t    mid_pos;   // lowest such leaf word within the mid word
    logic     top_hit;   // a later nonzero mid word
    mid_idx_t top_pos;   // lowest such mid word
  } hint_t;

  // Position of the lowest set bit; 0 for an empty word
  function automatic lane_t lowest_bit(word_t w);
    lane_t pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = lane_t'(i);
      end
    end
    return pos;
  endfunction

  // Bits of w strictly above position b
  function automatic word_t bits_above(word_t w, lane_t b);
    return w & ((~word_t'(0) << b) << 1);
  endfunction

endpackage

[rtl/isucc_leaf_ram.sv]
// isucc_leaf_ram: leaf bitmap store, one bit per key, one write and one read
// port with registered read data. Depends on isucc_pkg.
module isucc_leaf_ram (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  isucc_pkg::leaf_idx_t rd_addr_i,
  output isucc_pkg::word_t    rd_data_o,
  input  logic                wr_en_i,
  input  isucc_pkg::leaf_idx_t wr_addr_i,
  input  isucc_pkg::word_t    wr_data_i
);

  isucc_pkg::word_t mem_q [isucc_pkg::LEAF_WORDS];
  isucc_pkg::word_t rd_data_q;

  // Entries are never cleared; the mid summary tells which ones hold data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/isucc_summary.sv]
// isucc_summary: mid and top summary bitmaps in flops, with the lookups that
// steer a successor search. Depends on isucc_pkg.
module isucc_summary (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 set_i,
  input  isucc_pkg::leaf_idx_t set_leaf_i,
  input  isucc_pkg::key_t      look_key_i,
  input  logic                 alt_sel_i,
  input  isucc_pkg::mid_idx_t  alt_mid_i,
  output isucc_pkg::hint_t     hint_o,
  output isucc_pkg::lane_t     alt_pos_o
);

  isucc_pkg::word_t    mid_q [isucc_pkg::MID_WORDS];
  isucc_pkg::top_vec_t top_q;

  isucc_pkg::leaf_idx_t key_leaf;
  isucc_pkg::mid_idx_t  key_mid;
  isucc_pkg::lane_t     key_lane;
  isucc_pkg::mid_idx_t  set_mid;
  isucc_pkg::lane_t     set_lane;
  isucc_pkg::mid_idx_t  rd_idx;
  isucc_pkg::word_t     row;
  isucc_pkg::word_t     mid_above;
  isucc_pkg::top_vec_t  top_above;

  assign set_mid  = set_leaf_i[isucc_pkg::LEAF_W-1 -: isucc_pkg::MID_W];
  assign set_lane = set_leaf_i[isucc_pkg::WORD_SHIFT-1:0];

  // Mark a leaf word and its mid word as nonzero on insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < isucc_pkg::MID_WORDS; i++) begin
        mid_q[i] <= '0;
      end
      top_q <= '0;
    end else if (set_i) begin
      mid_q[set_mid][set_lane] <= 1'b1;
      top_q[set_mid]           <= 1'b1;
    end
  end

  // Key split
  assign key_leaf = look_key_i[isucc_pkg::KEY_W-1:isucc_pkg::WORD_SHIFT];
  assign key_mid  = key_leaf[isucc_pkg::LEAF_W-1 -: isucc_pkg::MID_W];
  assign key_lane = key_leaf[isucc_pkg::WORD_SHIFT-1:0];

  // Single read port on the mid rows: key's row, or the row picked by top
  assign rd_idx = alt_sel_i ? alt_mid_i : key_mid;
  assign row    = mid_q[rd_idx];

  assign mid_above = isucc_pkg::bits_above(row, key_lane);
  assign top_above = top_q & ((~isucc_pkg::top_vec_t'(0) << key_mid) << 1);

  always_comb begin
    hint_o.leaf_ok = row[key_lane];
    hint_o.mid_hit = |mid_above;
    hint_o.mid_pos = isucc_pkg::lowest_bit(mid_above);
    hint_o.top_hit = |top_above;
    hint_o.top_pos = isucc_pkg::mid_idx_t'(
                       isucc_pkg::lowest_bit(isucc_pkg::word_t'(top_above)));
  end

  // Lowest nonzero leaf word under the selected mid row
  assign alt_pos_o = isucc_pkg::lowest_bit(row);

endmodule

[rtl/integer_set_successor.sv]
// Integer set with insert, membership query and successor search over
// 16-bit keys, kept as a leaf bitmap memory (1024 x 64) plus mid and top
// summary bitmaps. One transaction is in work at a time. Insert, query and a
// successor search that ends in the key's own leaf word (a hit there, or no
// successor at all) need one leaf memory read, then the result register; a
// successor that lies in a later leaf word needs a second leaf read first.
// The result register lets the next transaction be accepted while a
// result still waits. The set is empty after reset with no clearing pass:
// a leaf word counts only once its summary bit is set. Op 3 gives found 0.
// Depends on isucc_pkg, isucc_leaf_ram and isucc_summary.
module integer_set_successor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  isucc_pkg::isucc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output isucc_pkg::isucc_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LEAF = 3'b010,
    ST_ALT  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [1:0]            op_q;
  isucc_pkg::key_t       key_q;
  isucc_pkg::hint_t      hint_q;
  isucc_pkg::leaf_idx_t  alt_leaf_q, alt_leaf_d;
  isucc_pkg::isucc_out_t out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  res_en;

  isucc_pkg::hint_t      hint;
  isucc_pkg::lane_t      alt_pos;

  logic                  rd_en;
  isucc_pkg::leaf_idx_t  rd_addr;
  isucc_pkg::word_t      rd_data;
  logic                  wr_en;
  isucc_pkg::word_t      wr_data;

  isucc_pkg::leaf_idx_t  cur_leaf;
  isucc_pkg::lane_t      cur_lane;
  isucc_pkg::word_t      cur_word;
  isucc_pkg::word_t      cur_above;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Current transaction's key split and masked leaf word
  assign cur_leaf  = key_q[isucc_pkg::KEY_W-1:isucc_pkg::WORD_SHIFT];
  assign cur_lane  = key_q[isucc_pkg::WORD_SHIFT-1:0];
  assign cur_word  = hint_q.leaf_ok ? rd_data : '0;
  assign cur_above = isucc_pkg::bits_above(cur_word, cur_lane);

  isucc_leaf_ram u_leaf (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (cur_leaf),
    .wr_data_i (wr_data)
  );

  isucc_summary u_summary (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .set_i      (wr_en),
    .set_leaf_i (cur_leaf),
    .look_key_i (in_data_i.key),
    .alt_sel_i  (state_q == ST_LEAF),
    .alt_mid_i  (hint_q.top_pos),
    .hint_o     (hint),
    .alt_pos_o  (alt_pos)
  );

  // Sequencer: leaf read on accept, then resolve or fetch a later leaf word
  always_comb begin
    state_d    = state_q;
    alt_leaf_d = alt_leaf_q;
    rd_en      = 1'b0;
    rd_addr    = in_data_i.key[isucc_pkg::KEY_W-1:isucc_pkg::WORD_SHIFT];
    wr_en      = 1'b0;
    wr_data    = cur_word | (isucc_pkg::word_t'(1) << cur_lane);
    res_en     = 1'b0;
    out_d      = out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rd_en   = 1'b1;
          state_d = ST_LEAF;
        end
      end
      ST_LEAF: begin
        if (out_free) begin
          state_d        = ST_IDLE;
          out_d.found    = 1'b0;
          out_d.next_key = '0;
          case (op_q)
            isucc_pkg::OP_INSERT: begin
              wr_en       = 1'b1;
              res_en      = 1'b1;
              out_d.found = 1'b1;
            end
            isucc_pkg::OP_QUERY: begin
              res_en      = 1'b1;
              out_d.found = cur_word[cur_lane];
            end
            isucc_pkg::OP_SUCC: begin
              if (|cur_above) begin
                res_en         = 1'b1;
                out_d.found    = 1'b1;
                out_d.next_key = {cur_leaf, isucc_pkg::lowest_bit(cur_above)};
              end else if (hint_q.mid_hit) begin
                alt_leaf_d = {cur_leaf[isucc_pkg::LEAF_W-1 -: isucc_pkg::MID_W],
                              hint_q.mid_pos};
                rd_en      = 1'b1;
                rd_addr    = alt_leaf_d;
                state_d    = ST_ALT;
              end else if (hint_q.top_hit) begin
                alt_leaf_d = {hint_q.top_pos, alt_pos};
                rd_en      = 1'b1;
                rd_addr    = alt_leaf_d;
                state_d    = ST_ALT;
              end else begin
                res_en = 1'b1;
              end
            end
            default: begin
              res_en = 1'b1;
            end
          endcase
        end
      end
      ST_ALT: begin
        // Target leaf word is known nonzero
        if (out_free) begin
          res_en         = 1'b1;
          out_d.found    = 1'b1;
          out_d.next_key = {alt_leaf_q, isucc_pkg::lowest_bit(rd_data)};
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_en) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= in_data_i.op;
      key_q  <= in_data_i.key;
      hint_q <= hint;
    end
    alt_leaf_q <= alt_leaf_d;
    if (res_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
